/* rtl/quaternion_vector_rotate_assert.svh */
// Assertion macros for the quaternion vector rotation block.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QVR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qvr_pkg.sv */
// Package with the default widths of the quaternion vector rotation block.
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

endpackage

/* rtl/quaternion_vector_rotate.sv */
// Five-stage pipelined rotation of a vector by conj(q) * (0, v) * q.
// An accepted input item passes the product, sum, product, sum and output registers in turn.
// Throughput: one item per cycle; the whole pipeline advances together and holds on a stall.
// The rate is set by the single output register, which frees whenever its item is taken.
// Reset clears the valid bits of all stages; data registers are not reset.
// There is no state between items, so no clearing pass follows reset.
`timescale 1ns / 1ps

`include "quaternion_vector_rotate_assert.svh"

module quaternion_vector_rotate #(
    parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qvr_pkg::FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z (lowest bits first)
    input  logic [((7*DATA_WIDTH+7)/8)*8-1:0]         s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // rot_x, rot_y, rot_z (lowest bits first)
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]         m_tdata,
    // clipped
    output logic [0:0]                                m_tuser
);

    import qvr_pkg::*;

    localparam int OUT_W   = ((3*DATA_WIDTH+7)/8)*8;
    localparam int P1_W    = 2*DATA_WIDTH;
    localparam int S1_FULL = P1_W + 2;
    // Sums wrap at 64 bits, as two's complement words do.
    localparam int S1_W    = (S1_FULL > 64) ? 64 : S1_FULL;
    localparam int T_W     = (S1_W - FRAC_BITS > 1) ? (S1_W - FRAC_BITS) : 1;
    localparam int P2_W    = T_W + DATA_WIDTH;
    localparam int S2_FULL = P2_W + 2;
    localparam int S2_W    = (S2_FULL > 64) ? 64 : S2_FULL;
    localparam int R_W     = (S2_W - FRAC_BITS > DATA_WIDTH) ? (S2_W - FRAC_BITS) : DATA_WIDTH;

    localparam logic signed [R_W-1:0] SAT_MAX =
        $signed({{(R_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [R_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] OUT_MIN = ~OUT_MAX;

    // Pipeline valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic adv;

    // Input fields: quaternion w, x, y, z and vector x, y, z.
    logic signed [DATA_WIDTH-1:0] qi [4];
    logic signed [DATA_WIDTH-1:0] vi [3];

    logic signed [P1_W-1:0]       p1_reg  [12];
    logic signed [P1_W-1:0]       p1_next [12];
    logic signed [DATA_WIDTH-1:0] q1_reg  [4];
    logic signed [T_W-1:0]        t_reg   [4];
    logic signed [T_W-1:0]        t_next  [4];
    logic signed [DATA_WIDTH-1:0] q2_reg  [4];
    logic signed [P2_W-1:0]       p2_reg  [12];
    logic signed [P2_W-1:0]       p2_next [12];
    logic signed [R_W-1:0]        r_reg   [3];
    logic signed [R_W-1:0]        r_next  [3];
    logic [DATA_WIDTH-1:0]        rot_reg  [3];
    logic [DATA_WIDTH-1:0]        rot_next [3];
    logic                         clip_reg;
    logic                         clip_next;
    logic                         any_at_limit;

    logic signed [S1_FULL-1:0]    sum1  [4];
    logic signed [S1_W-1:0]       sum1w [4];
    logic signed [S2_FULL-1:0]    sum2  [3];
    logic signed [S2_W-1:0]       sum2w [3];

    // The output register is the last stage; everything moves when it can take an item.
    assign adv      = !vo_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vo_reg;
    assign m_tdata  = OUT_W'({rot_reg[2], rot_reg[1], rot_reg[0]});
    assign m_tuser  = clip_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            qi[k] = $signed(s_tdata[k*DATA_WIDTH +: DATA_WIDTH]);
        end
        for (int k = 0; k < 3; k++)
        begin
            vi[k] = $signed(s_tdata[(k+4)*DATA_WIDTH +: DATA_WIDTH]);
        end
    end

    // Stage 1: products of conj(q) * (0, v), signs folded into the sums.
    always_comb
    begin
        p1_next[0]  = qi[1] * vi[0];
        p1_next[1]  = qi[2] * vi[1];
        p1_next[2]  = qi[3] * vi[2];
        p1_next[3]  = qi[0] * vi[0];
        p1_next[4]  = qi[2] * vi[2];
        p1_next[5]  = qi[3] * vi[1];
        p1_next[6]  = qi[0] * vi[1];
        p1_next[7]  = qi[3] * vi[0];
        p1_next[8]  = qi[1] * vi[2];
        p1_next[9]  = qi[0] * vi[2];
        p1_next[10] = qi[1] * vi[1];
        p1_next[11] = qi[2] * vi[0];
    end

    // Stage 2: sums of the first product, then the fraction shift.
    always_comb
    begin
        sum1[0] = S1_FULL'(p1_reg[0]) + S1_FULL'(p1_reg[1]) + S1_FULL'(p1_reg[2]);
        sum1[1] = S1_FULL'(p1_reg[3]) - S1_FULL'(p1_reg[4]) + S1_FULL'(p1_reg[5]);
        sum1[2] = S1_FULL'(p1_reg[6]) - S1_FULL'(p1_reg[7]) + S1_FULL'(p1_reg[8]);
        sum1[3] = S1_FULL'(p1_reg[9]) - S1_FULL'(p1_reg[10]) + S1_FULL'(p1_reg[11]);
        for (int k = 0; k < 4; k++)
        begin
            sum1w[k]  = S1_W'(sum1[k]);
            t_next[k] = T_W'(sum1w[k] >>> FRAC_BITS);
        end
    end

    // Stage 3: products of t * q for the vector part only.
    always_comb
    begin
        p2_next[0]  = t_reg[1] * q2_reg[0];
        p2_next[1]  = t_reg[0] * q2_reg[1];
        p2_next[2]  = t_reg[2] * q2_reg[3];
        p2_next[3]  = t_reg[3] * q2_reg[2];
        p2_next[4]  = t_reg[2] * q2_reg[0];
        p2_next[5]  = t_reg[0] * q2_reg[2];
        p2_next[6]  = t_reg[3] * q2_reg[1];
        p2_next[7]  = t_reg[1] * q2_reg[3];
        p2_next[8]  = t_reg[3] * q2_reg[0];
        p2_next[9]  = t_reg[0] * q2_reg[3];
        p2_next[10] = t_reg[1] * q2_reg[2];
        p2_next[11] = t_reg[2] * q2_reg[1];
    end

    // Stage 4: sums of the second product, then the fraction shift.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum2[k] = S2_FULL'(p2_reg[4*k]) + S2_FULL'(p2_reg[4*k+1])
                    + S2_FULL'(p2_reg[4*k+2]) - S2_FULL'(p2_reg[4*k+3]);
            sum2w[k]  = S2_W'(sum2[k]);
            r_next[k] = R_W'(sum2w[k] >>> FRAC_BITS);
        end
    end

    // Stage 5: saturation to the output width.
    always_comb
    begin
        clip_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (r_reg[k] > SAT_MAX)
            begin
                rot_next[k] = OUT_MAX;
                clip_next   = 1'b1;
            end
            else if (r_reg[k] < SAT_MIN)
            begin
                rot_next[k] = OUT_MIN;
                clip_next   = 1'b1;
            end
            else
            begin
                rot_next[k] = r_reg[k][DATA_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 12; k++)
            begin
                p1_reg[k] <= p1_next[k];
                p2_reg[k] <= p2_next[k];
            end
            for (int k = 0; k < 4; k++)
            begin
                q1_reg[k] <= qi[k];
                q2_reg[k] <= q1_reg[k];
                t_reg[k]  <= t_next[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                r_reg[k]   <= r_next[k];
                rot_reg[k] <= rot_next[k];
            end
            clip_reg <= clip_next;
        end
    end

    assign any_at_limit = rot_reg[0] == OUT_MAX || rot_reg[0] == OUT_MIN
                       || rot_reg[1] == OUT_MAX || rot_reg[1] == OUT_MIN
                       || rot_reg[2] == OUT_MAX || rot_reg[2] == OUT_MIN;

    `QVR_ASSERT_NEXT(a_stall_holds_stage1, !adv, $stable(v1_reg), "stage 1 valid moved on a stall")
    `QVR_ASSERT_NEXT(a_stage4_to_output, adv && v4_reg, vo_reg, "item lost between stage 4 and output")
    `QVR_ASSERT_NOW(a_clip_at_limit, vo_reg && clip_reg, any_at_limit, "clipped with no limit hit")

endmodule

/* sim/qvr_rotation_checker.sv */
// Checker that watches both streams of the rotation block, predicts each result and compares.
`timescale 1ns / 1ps

module qvr_rotation_checker #(
    parameter int DW   = qvr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC = qvr_pkg::FRAC_BITS_DEF,
    parameter int S_W  = ((7*DW+7)/8)*8,
    parameter int M_W  = ((3*DW+7)/8)*8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [S_W-1:0] s_tdata,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [M_W-1:0] m_tdata,
    input  logic [0:0]     m_tuser,
    output int             fail_count,
    output int             pending,
    output int             checked,
    output int             clipped_seen
);

    typedef logic signed [63:0] wide_t;

    typedef struct packed {
        wide_t w;
        wide_t x;
        wide_t y;
        wide_t z;
    } quat_t;

    typedef struct packed {
        logic [DW-1:0] rx;
        logic [DW-1:0] ry;
        logic [DW-1:0] rz;
        logic          clip;
    } rotation_t;

    rotation_t pending_rotations[$];
    int        mismatches = 0;
    int        n_pending = 0;
    int        n_checked = 0;
    int        n_clipped = 0;

    assign fail_count   = mismatches;
    assign pending      = n_pending;
    assign checked      = n_checked;
    assign clipped_seen = n_clipped;

    // Products wrap modulo 2**64; only the final shift needs the sign.
    function automatic quat_t hamilton_shift(input quat_t a, input quat_t b);
        wide_t s0, s1, s2, s3;
        quat_t r;
        s0 = a.w*b.w - a.x*b.x - a.y*b.y - a.z*b.z;
        s1 = a.w*b.x + a.x*b.w + a.y*b.z - a.z*b.y;
        s2 = a.w*b.y + a.y*b.w + a.z*b.x - a.x*b.z;
        s3 = a.w*b.z + a.z*b.w + a.x*b.y - a.y*b.x;
        r.w = s0 >>> FRAC;
        r.x = s1 >>> FRAC;
        r.y = s2 >>> FRAC;
        r.z = s3 >>> FRAC;
        return r;
    endfunction

    function automatic logic [DW-1:0] saturate(input wide_t v, inout logic clip);
        wide_t hi, lo;
        hi = (64'sd1 <<< (DW-1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
        begin
            clip = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo)
        begin
            clip = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // Body-to-global rotation: conj(q) * (0, v) * q, keeping the vector part.
    function automatic rotation_t rotate_body_to_global(input logic [S_W-1:0] item);
        quat_t     q, qc, pv, t, r;
        rotation_t e;
        logic      clip;
        q.w  = $signed(item[0*DW +: DW]);
        q.x  = $signed(item[1*DW +: DW]);
        q.y  = $signed(item[2*DW +: DW]);
        q.z  = $signed(item[3*DW +: DW]);
        pv.w = '0;
        pv.x = $signed(item[4*DW +: DW]);
        pv.y = $signed(item[5*DW +: DW]);
        pv.z = $signed(item[6*DW +: DW]);
        qc.w = q.w;
        qc.x = -q.x;
        qc.y = -q.y;
        qc.z = -q.z;
        t = hamilton_shift(qc, pv);
        r = hamilton_shift(t, q);
        clip = 1'b0;
        e.rx = saturate(r.x, clip);
        e.ry = saturate(r.y, clip);
        e.rz = saturate(r.z, clip);
        e.clip = clip;
        return e;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", n_checked, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        rotation_t     want;
        logic [DW-1:0] got_x, got_y, got_z;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_x = m_tdata[0*DW +: DW];
                got_y = m_tdata[1*DW +: DW];
                got_z = m_tdata[2*DW +: DW];
                if (pending_rotations.size() == 0)
                begin
                    report_mismatch("result item with no input item waiting");
                end
                else
                begin
                    want = pending_rotations.pop_front();
                    if (got_x !== want.rx)
                        report_mismatch($sformatf("rot_x got %0d expected %0d",
                                                  $signed(got_x), $signed(want.rx)));
                    if (got_y !== want.ry)
                        report_mismatch($sformatf("rot_y got %0d expected %0d",
                                                  $signed(got_y), $signed(want.ry)));
                    if (got_z !== want.rz)
                        report_mismatch($sformatf("rot_z got %0d expected %0d",
                                                  $signed(got_z), $signed(want.rz)));
                    if (m_tuser[0] !== want.clip)
                        report_mismatch($sformatf("clipped got %b expected %b",
                                                  m_tuser[0], want.clip));
                    if (want.clip)
                        n_clipped++;
                    n_checked++;
                end
            end
            if (s_tvalid && s_tready)
                pending_rotations.push_back(rotate_body_to_global(s_tdata));
            n_pending = pending_rotations.size();
        end
    end

endmodule

/* sim/tb_top.sv */
// Top of the rotation block testbench: clock, reset, stream stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int DW          = qvr_pkg::DATA_WIDTH_DEF;
    localparam int FRAC        = qvr_pkg::FRAC_BITS_DEF;
    localparam int S_W         = ((7*DW+7)/8)*8;
    localparam int M_W         = ((3*DW+7)/8)*8;
    localparam int HOLD_CYCLES = 200;
    localparam int ONE         = 1 << FRAC;
    localparam int COS45       = 11585;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;
    logic [0:0]     m_tuser;

    int fail_count;
    int pending;
    int checked;
    int clipped_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks = 0;

    always #5 clk = ~clk;

    quaternion_vector_rotate #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    qvr_rotation_checker #(
        .DW   (DW),
        .FRAC (FRAC)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .clipped_seen (clipped_seen)
    );

    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d results outstanding.", pending);
        $display("quaternion_vector_rotate verification failed");
        $finish;
    end

    // Output side: random back-pressure, plus a long hold-off whenever one is asked for.
    initial
    begin
        int served;
        served = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != served)
            begin
                served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    function automatic logic [S_W-1:0] pack_rotation(input int w, input int x, input int y,
                                                     input int z, input int vx, input int vy,
                                                     input int vz);
        logic [S_W-1:0] item;
        item = '0;
        item[0*DW +: DW] = w[DW-1:0];
        item[1*DW +: DW] = x[DW-1:0];
        item[2*DW +: DW] = y[DW-1:0];
        item[3*DW +: DW] = z[DW-1:0];
        item[4*DW +: DW] = vx[DW-1:0];
        item[5*DW +: DW] = vy[DW-1:0];
        item[6*DW +: DW] = vz[DW-1:0];
        return item;
    endfunction

    // Mostly plausible attitudes with gain at most one, otherwise raw bit patterns that
    // clip often or tiny values that exercise rounding toward minus infinity.
    function automatic logic [S_W-1:0] random_rotation();
        int             kind;
        int             f[7];
        logic [S_W-1:0] item;
        kind = $urandom_range(99, 0);
        for (int k = 0; k < 7; k++)
        begin
            if (kind < 55)
                f[k] = (k < 4) ? int'($urandom_range(ONE, 0)) - ONE / 2 : int'($urandom);
            else if (kind < 80)
                f[k] = $urandom;
            else
                f[k] = int'($urandom_range(128, 0)) - 64;
        end
        item = '0;
        for (int k = 0; k < 7; k++)
            item[k*DW +: DW] = f[k][DW-1:0];
        return item;
    endfunction

    // Called at a falling edge; returns at a falling edge after the item is taken.
    task automatic send_rotation(input logic [S_W-1:0] item);
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 62;

        // Identity, negated identity and the zero quaternion.
        send_rotation(pack_rotation(ONE, 0, 0, 0, 1000, -2000, 3000));
        send_rotation(pack_rotation(ONE, 0, 0, 0, 32767, -32768, -1));
        send_rotation(pack_rotation(-ONE, 0, 0, 0, -32768, 32767, 0));
        send_rotation(pack_rotation(0, 0, 0, 0, 32767, 32767, 32767));
        // Quarter turns about z and x and half turns about each axis.
        send_rotation(pack_rotation(COS45, 0, 0, COS45, 1000, 0, 0));
        send_rotation(pack_rotation(COS45, COS45, 0, 0, 0, 1000, -1000));
        send_rotation(pack_rotation(0, ONE, 0, 0, 1234, 5678, -910));
        send_rotation(pack_rotation(0, 0, ONE, 0, 1234, 5678, -910));
        send_rotation(pack_rotation(0, 0, 0, ONE, 1234, 5678, -910));
        // Every field at its extremes, which saturates hard.
        send_rotation(pack_rotation(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_rotation(pack_rotation(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_rotation(pack_rotation(-32768, 32767, -32768, 32767, 32767, -32768, 32767));
        // Unnormalized gain of about four pushes a moderate vector into clipping.
        send_rotation(pack_rotation(32767, 0, 0, 0, 20000, -20000, 5000));
        send_rotation(pack_rotation(32767, 0, 0, 0, 4095, -4096, 100));
        // Tiny values where the floor rounding of each fraction shift shows.
        send_rotation(pack_rotation(1, 1, 1, 1, -1, -1, -1));
        send_rotation(pack_rotation(-1, 1, -1, 1, 1, -1, 1));
        send_rotation(pack_rotation(ONE, 1, -1, 0, -3, 7, -5));
        // Alternating bit patterns on every field.
        send_rotation(pack_rotation(16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                                    16'haaaa, 16'h5555, 16'haaaa));
        send_rotation(pack_rotation(16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                                    16'h5555, 16'haaaa, 16'h5555));

        repeat (500) send_rotation(random_rotation());

        send_idle_pct = 62;
        recv_idle_pct = 18;
        repeat (500) send_rotation(random_rotation());

        // Let the pipeline drain completely before the next burst.
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);

        // Full-rate stream against a long output stall, then full rate both ways.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks = hold_asks + 1;
        repeat (600) send_rotation(random_rotation());
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);

        $display("Checked %0d rotations (%0d saturated) across directed attitudes and extremes,",
                 checked, clipped_seen);
        $display("random stalls on either side, a long output hold-off and a drained pause.");
        if (fail_count == 0)
            $display("quaternion_vector_rotate verification clean");
        else
            $display("quaternion_vector_rotate verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate.sv
sim/qvr_rotation_checker.sv
sim/tb_top.sv
